/* rtl/core/dlr_pkg.sv */
// shared types and constants for the dense layer with relu
// command layout between the front end, the queue and the back end
// no dependencies
`default_nettype none

package dlr_pkg;

    // default store sizes, overridable on the top level
    localparam int MAX_IN_DEF  = 64;
    localparam int MAX_OUT_DEF = 64;

    // fixed field widths
    localparam int DATA_W    = 16;
    localparam int IDX_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int OUT_W     = 15;
    localparam int FRAC_BITS = 8;

    // command queue depth
    localparam int QDEPTH = 4;

    // configuration register indexes
    localparam logic CFG_IN_SIZE  = 1'b0;
    localparam logic CFG_OUT_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_WGT  = 2'd0,
        FUNC_BIAS = 2'd1,
        FUNC_INP  = 2'd2
    } func_t;

    // one queued command
    typedef struct packed {
        func_t                    op;
        logic                     wr;    // store write in range
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] data;
        logic                     run;   // last input element, start the layer
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/dlr_front.sv */
// front end: accepts input items, decodes the function and range checks indexes
// pushes store writes and layer starts into the command queue
// depends on dlr_pkg
`default_nettype none

module dlr_front #(
    parameter int MAX_IN  = dlr_pkg::MAX_IN_DEF,
    parameter int MAX_OUT = dlr_pkg::MAX_OUT_DEF
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_func,
    input  logic [dlr_pkg::IDX_W-1:0]         s_row_index,
    input  logic [dlr_pkg::IDX_W-1:0]         s_col_index,
    input  logic signed [dlr_pkg::DATA_W-1:0] s_value,
    input  logic                              s_last,
    output logic                              push_valid,
    input  logic                              push_ready,
    output dlr_pkg::cmd_t                     push_cmd
);
    import dlr_pkg::*;

    logic row_ok;
    logic col_ok;
    logic keep;

    always_comb begin
        row_ok        = int'(s_row_index) < MAX_IN;
        col_ok        = int'(s_col_index) < MAX_OUT;
        push_cmd.op   = FUNC_INP;
        push_cmd.wr   = 1'b0;
        push_cmd.row  = s_row_index;
        push_cmd.col  = s_col_index;
        push_cmd.data = s_value;
        push_cmd.run  = 1'b0;
        keep          = 1'b0;
        case (s_func)
            FUNC_WGT: begin
                push_cmd.op = FUNC_WGT;
                push_cmd.wr = row_ok && col_ok;
                keep        = row_ok && col_ok;
            end
            FUNC_BIAS: begin
                push_cmd.op = FUNC_BIAS;
                push_cmd.wr = col_ok;
                keep        = col_ok;
            end
            FUNC_INP: begin
                push_cmd.op  = FUNC_INP;
                push_cmd.wr  = row_ok;
                push_cmd.run = s_last;
                keep         = row_ok || s_last;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // items that change nothing are taken and dropped
    assign s_ready    = push_ready;
    assign push_valid = s_valid && keep;

endmodule

`default_nettype wire

/* rtl/core/dlr_queue.sv */
// short command fifo between the front end and the back end
// depends on dlr_pkg
`default_nettype none

module dlr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dlr_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output dlr_pkg::cmd_t out_cmd
);
    import dlr_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    cmd_t             slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != (QAW+1)'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        count_next = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dlr_back.sv */
// back end: weight, bias and input stores, shared multiply-accumulate,
// neuron sequencer, relu with rounding and saturation, result register
// depends on dlr_pkg
`default_nettype none

module dlr_back #(
    parameter int MAX_IN  = dlr_pkg::MAX_IN_DEF,
    parameter int MAX_OUT = dlr_pkg::MAX_OUT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [$clog2(MAX_IN+1)-1:0]      n_in,
    input  logic [$clog2(MAX_OUT+1)-1:0]     n_out,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  dlr_pkg::cmd_t                    q_cmd,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dlr_pkg::IDX_W-1:0]        m_out_index,
    output logic [dlr_pkg::OUT_W-1:0]        m_out_value,
    output logic                             m_out_last
);
    import dlr_pkg::*;

    localparam int NIN_W  = $clog2(MAX_IN + 1);
    localparam int NOUT_W = $clog2(MAX_OUT + 1);
    localparam int IN_AW  = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int OUT_AW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int WDEPTH = MAX_IN * MAX_OUT;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int ACC_W  = 2 * DATA_W + $clog2(MAX_IN + 1) + 2;
    localparam int SAT_LO = FRAC_BITS + OUT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    // stores
    logic signed [DATA_W-1:0] wgt_mem  [WDEPTH];
    logic signed [DATA_W-1:0] bias_mem [MAX_OUT];
    logic signed [DATA_W-1:0] in_mem   [MAX_IN];

    state_t                   state_reg;
    state_t                   state_next;
    logic [IN_AW-1:0]         i_reg;
    logic [IN_AW-1:0]         i_next;
    logic [OUT_AW-1:0]        o_reg;
    logic [OUT_AW-1:0]        o_next;
    logic [WA_W-1:0]          wa_reg;
    logic [WA_W-1:0]          wa_next;

    logic signed [DATA_W-1:0]   in_rd_reg;
    logic signed [DATA_W-1:0]   w_rd_reg;
    logic signed [DATA_W-1:0]   bias_rd_reg;
    logic                       rd_v_reg;
    logic                       bias_v_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       prod_v_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_index_reg;
    logic [OUT_W-1:0]         m_value_reg;
    logic                     m_last_reg;

    logic                     pop;
    logic                     issue_last;
    logic                     o_last;
    logic                     out_free;
    logic                     load_out;
    logic [WA_W-1:0]          wr_addr;
    logic [ACC_W-1:0]         rnd;
    logic [OUT_W-1:0]         relu_val;

    assign q_ready    = state_reg == ST_IDLE;
    assign pop        = q_valid && q_ready;
    assign issue_last = (n_in == '0) || (NIN_W'(i_reg) + NIN_W'(1) == n_in);
    assign o_last     = NOUT_W'(o_reg) + NOUT_W'(1) == n_out;
    assign out_free   = !m_valid_reg || m_ready;
    assign wr_addr    = WA_W'(int'(q_cmd.row) * MAX_OUT + int'(q_cmd.col));

    // relu, round half up, saturate
    assign rnd = acc_reg + ACC_W'(1 << (FRAC_BITS - 1));
    always_comb begin
        if (acc_reg[ACC_W-1] || acc_reg == '0) begin
            relu_val = '0;
        end else if (|rnd[ACC_W-1:SAT_LO]) begin
            relu_val = '1;
        end else begin
            relu_val = rnd[SAT_LO-1:FRAC_BITS];
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        o_next     = o_reg;
        wa_next    = wa_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_cmd.op == FUNC_INP && q_cmd.run && n_out != '0) begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    o_next     = '0;
                    wa_next    = '0;
                end
            end
            ST_RUN: begin
                if (issue_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    i_next  = i_reg + IN_AW'(1);
                    wa_next = wa_reg + WA_W'(MAX_OUT);
                end
            end
            ST_FLUSH: begin
                if (!rd_v_reg && !prod_v_reg && !bias_v_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (o_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RUN;
                        o_next     = o_reg + OUT_AW'(1);
                        i_next     = '0;
                        wa_next    = WA_W'(o_reg) + WA_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            o_reg       <= '0;
            wa_reg      <= '0;
            rd_v_reg    <= 1'b0;
            bias_v_reg  <= 1'b0;
            prod_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            o_reg       <= o_next;
            wa_reg      <= wa_next;
            rd_v_reg    <= (state_reg == ST_RUN) && (n_in != '0);
            bias_v_reg  <= (state_reg == ST_RUN) && (i_reg == '0);
            prod_v_reg  <= rd_v_reg;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // store writes
    always_ff @(posedge aclk) begin
        if (pop && q_cmd.wr && q_cmd.op == FUNC_WGT) begin
            wgt_mem[wr_addr] <= q_cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_cmd.wr && q_cmd.op == FUNC_BIAS) begin
            bias_mem[OUT_AW'(q_cmd.col)] <= q_cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_cmd.wr && q_cmd.op == FUNC_INP) begin
            in_mem[IN_AW'(q_cmd.row)] <= q_cmd.data;
        end
    end

    // registered store reads
    always_ff @(posedge aclk) begin
        w_rd_reg    <= wgt_mem[wa_reg];
        in_rd_reg   <= in_mem[i_reg];
        bias_rd_reg <= bias_mem[o_reg];
    end

    // multiply, then accumulate; bias lands in the cycle before the first product
    always_ff @(posedge aclk) begin
        prod_reg <= in_rd_reg * w_rd_reg;
        if (bias_v_reg) begin
            acc_reg <= ACC_W'(bias_rd_reg) <<< FRAC_BITS;
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_index_reg <= IDX_W'(o_reg);
            m_value_reg <= relu_val;
            m_last_reg  <= o_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = m_index_reg;
    assign m_out_value = m_value_reg;
    assign m_out_last  = m_last_reg;

endmodule

`default_nettype wire

/* rtl/core/dense_layer_relu_forward.sv */
// top level of the dense layer forward pass with relu, signed q8.8
// holds the size registers and joins front end, command queue and back end
// depends on dlr_pkg, dlr_front, dlr_queue, dlr_back
//
//   channel   ports                                   direction   transfer when
//   input     s_valid s_ready s_func s_row_index      in          s_valid && s_ready
//             s_col_index s_value s_last
//   result    m_valid m_ready m_out_index             out         m_valid && m_ready
//             m_out_value m_out_last
//   config    cfg_we cfg_index cfg_data               in          cfg_we
//
// a weight, bias or input element is written into its store when the back end
// pops it from the queue; an input element marked last starts the layer, which
// computes the neurons in turn on the single shared 16x16 mac and the one read
// port of the weight store
// aresetn is synchronous and active low; it clears control and sets both sizes
// to 64, while the stores stay undefined until written (no clearing pass)
// the queue lets the front end keep taking items while the back end computes;
// a stalled result holds the back end in its output state
`default_nettype none

module dense_layer_relu_forward #(
    parameter int MAX_IN  = dlr_pkg::MAX_IN_DEF,
    parameter int MAX_OUT = dlr_pkg::MAX_OUT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_func,
    input  logic [dlr_pkg::IDX_W-1:0]         s_row_index,
    input  logic [dlr_pkg::IDX_W-1:0]         s_col_index,
    input  logic signed [dlr_pkg::DATA_W-1:0] s_value,
    input  logic                              s_last,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dlr_pkg::IDX_W-1:0]         m_out_index,
    output logic [dlr_pkg::OUT_W-1:0]         m_out_value,
    output logic                              m_out_last,
    // configuration writes
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [dlr_pkg::SIZE_W-1:0]        cfg_data
);
    import dlr_pkg::*;

    localparam int NIN_W  = $clog2(MAX_IN + 1);
    localparam int NOUT_W = $clog2(MAX_OUT + 1);

    // size registers
    logic [SIZE_W-1:0] in_size_reg;
    logic [SIZE_W-1:0] out_size_reg;

    // sizes clamped to the store dimensions
    logic [NIN_W-1:0]  n_in;
    logic [NOUT_W-1:0] n_out;

    // front end to queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // queue to back end
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_size_reg  <= SIZE_RESET;
            out_size_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IN_SIZE:  in_size_reg  <= cfg_data;
                CFG_OUT_SIZE: out_size_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign n_in  = (int'(in_size_reg) > MAX_IN) ? NIN_W'(MAX_IN) : NIN_W'(in_size_reg);
    assign n_out = (int'(out_size_reg) > MAX_OUT) ? NOUT_W'(MAX_OUT) : NOUT_W'(out_size_reg);

    // decode and range check incoming items
    dlr_front #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .s_value     (s_value),
        .s_last      (s_last),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    // decouples item intake from layer computation
    dlr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // stores, mac and result register
    dlr_back #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .n_in        (n_in),
        .n_out       (n_out),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_index (m_out_index),
        .m_out_value (m_out_value),
        .m_out_last  (m_out_last)
    );

`ifndef SYNTH
    // commands are popped only in the idle state, so no result can appear right after a pop
    a_pop_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> !$rose(m_valid))
        else $error("result raised directly after a command pop");

    // a new result only comes out of the output state, where no command is popped
    a_result_from_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!q_ready))
        else $error("result raised while the back end was idle");

    // reset leaves no result pending
    a_reset_clears_result: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
